FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on aclk and
// is switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// If the condition holds now, the consequence holds at the same edge.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// If the condition holds now, the consequence holds at the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/olist_pkg.sv
package olist_pkg;

    localparam int MODE_W    = 2;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 7;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

endpackage

FILE: rtl/core/olist_ram.sv
module olist_ram import olist_pkg::*; #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [VALUE_W-1:0] wdata,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/ordered_list_engine.sv
// Channel  Dir  Fields (lowest bit first)
// s_       in   tuser: mode[1:0]; tdata: value[31:0], position[38:32], zero pad
// m_       out  tdata: ok[0], read_value[32:1], is_empty[33], zero pad
//
// The list is a circular buffer in one RAM with one write and one read port.
// Inserts and requests refused on entry go from ST_IDLE straight to ST_DONE; a read
// waits in ST_RDWAIT for the RAM data; a remove runs in ST_SCAN, with one RAM
// read per stored entry, and the tail is pulled forward during the same pass.
// One item is worked on at a time; s_tready is high only between items.
// A result that m_tready stalls stays in the output register; the next item
// is then accepted but its result waits until the register is free.
// Reset clears the state, entry count, head pointer, pend and found flags and m_tvalid; the RAM needs no clearing.
`include "assert_macros.svh"

module ordered_list_engine import olist_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // value[31:0], position[38:32]
    input  logic [MODE_W-1:0]    s_tuser,  // mode[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // ok[0], read_value[32:1], is_empty[33]
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OFS_W = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [IDX_W:0]   CAP_SUM  = (IDX_W + 1)'(CAPACITY);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_RDWAIT, ST_DONE} state_t;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
        return (a == LAST_IDX) ? '0 : a + 1'b1;
    endfunction

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0]   arr_addr_reg, arr_addr_next;
    logic [IDX_W-1:0]   prev_addr_reg, prev_addr_next;
    logic               pend_reg, pend_next;
    logic               found_reg, found_next;
    logic               res_ok_reg, res_ok_next;
    logic [VALUE_W-1:0] res_data_reg, res_data_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               m_ok_reg, m_ok_next;
    logic [VALUE_W-1:0] m_data_reg, m_data_next;
    logic               m_empty_reg, m_empty_next;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    logic [MODE_W-1:0]  in_mode;
    logic [VALUE_W-1:0] in_value;
    logic [POS_W-1:0]   in_pos;
    logic [OFS_W-1:0]   pos_m1;
    logic [IDX_W:0]     rd_sum;
    logic [IDX_W-1:0]   rd_addr;
    logic               pos_ok;
    logic               scan_issue;
    logic               scan_end;
    logic               accept;

    assign in_mode  = s_tuser;
    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_pos   = s_tdata[VALUE_W+POS_W-1:VALUE_W];
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Position p lives at head + p - 1, wrapped once around the buffer.
    assign pos_m1 = OFS_W'(in_pos) - 1'b1;
    assign rd_sum = {1'b0, head_reg} + {1'b0, pos_m1[IDX_W-1:0]};
    assign rd_addr = (rd_sum >= CAP_SUM) ? IDX_W'(rd_sum - CAP_SUM) : rd_sum[IDX_W-1:0];
    assign pos_ok = (in_pos != '0) && (CMP_W'(in_pos) <= CMP_W'(count_reg));

    assign scan_issue = (scan_cnt_reg != count_reg);
    assign scan_end   = !pend_reg && !scan_issue;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        val_next       = val_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_ptr_next    = rd_ptr_reg;
        arr_addr_next  = arr_addr_reg;
        prev_addr_next = prev_addr_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        res_ok_next    = res_ok_reg;
        res_data_next  = res_data_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_ok_next      = m_ok_reg;
        m_data_next    = m_data_reg;
        m_empty_next   = m_empty_reg;
        mem_we         = 1'b0;
        mem_waddr      = prev_addr_reg;
        mem_wdata      = mem_rdata;
        mem_raddr      = rd_ptr_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    val_next      = in_value;
                    res_ok_next   = 1'b0;
                    res_data_next = '0;
                    state_next    = ST_DONE;
                    case (in_mode)
                        MODE_INSERT: begin
                            if (count_reg != CAP_CNT) begin
                                head_next   = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
                                mem_we      = 1'b1;
                                mem_waddr   = head_next;
                                mem_wdata   = in_value;
                                count_next  = count_reg + 1'b1;
                                res_ok_next = 1'b1;
                            end
                        end
                        MODE_REMOVE: begin
                            if (count_reg != '0) begin
                                rd_ptr_next   = head_reg;
                                scan_cnt_next = '0;
                                pend_next     = 1'b0;
                                found_next    = 1'b0;
                                state_next    = ST_SCAN;
                            end
                        end
                        MODE_READ: begin
                            if (pos_ok) begin
                                mem_raddr  = rd_addr;
                                state_next = ST_RDWAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // One pass: read each entry in order; once the match is seen,
                // every later entry is written back one place toward the head.
                pend_next = 1'b0;
                if (scan_issue) begin
                    mem_raddr     = rd_ptr_reg;
                    rd_ptr_next   = wrap_inc(rd_ptr_reg);
                    arr_addr_next = rd_ptr_reg;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    pend_next     = 1'b1;
                end
                if (pend_reg) begin
                    if (found_reg) begin
                        mem_we = 1'b1;
                    end else if (mem_rdata == val_reg) begin
                        found_next = 1'b1;
                    end
                    prev_addr_next = arr_addr_reg;
                end
                if (scan_end) begin
                    res_ok_next = found_reg;
                    if (found_reg) begin
                        count_next = count_reg - 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_RDWAIT: begin
                res_ok_next   = 1'b1;
                res_data_next = mem_rdata;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_ok_next     = res_ok_reg;
                    m_data_next   = res_data_reg;
                    m_empty_next  = (count_reg == '0);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        val_reg       <= val_next;
        scan_cnt_reg  <= scan_cnt_next;
        rd_ptr_reg    <= rd_ptr_next;
        arr_addr_reg  <= arr_addr_next;
        prev_addr_reg <= prev_addr_next;
        res_ok_reg    <= res_ok_next;
        res_data_reg  <= res_data_next;
        m_ok_reg      <= m_ok_next;
        m_data_reg    <= m_data_next;
        m_empty_reg   <= m_empty_next;
    end

    olist_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - 2){1'b0}}, m_empty_reg, m_data_reg, m_ok_reg};

    `ASSERT_ALWAYS(a_count_in_range, count_reg <= CAP_CNT, "entry count exceeds capacity")
    `ASSERT_IMPLY(a_write_states, mem_we, state_reg == ST_IDLE || state_reg == ST_SCAN, "RAM written outside insert or remove")
    `ASSERT_NEXT(a_done_holds, state_reg == ST_DONE && m_tvalid_reg && !m_tready, state_reg == ST_DONE, "result dropped while output stalled")
    `ASSERT_NEXT(a_remove_count, state_reg == ST_SCAN && scan_end && found_reg, (count_reg + 1'b1) == $past(count_reg), "remove did not shorten the list by one")

endmodule
